// ===== hw/rtl/sfms_pkg.sv =====
// sfms_pkg: shared constants, register indexes and types for the substring search
// used by sfms_cfg, sfms_match and substring_first_match_search
// no dependencies
`default_nettype none

package sfms_pkg;

    // default sizes, handed to the top level parameters
    localparam int unsigned MAX_PATTERN_DEF = 32;
    localparam int unsigned MAX_TEXT_DEF    = 65536;

    // fixed widths of the register file and the stream fields
    localparam int unsigned PAT_BYTES  = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned WORD_BYTES = CFG_W / BYTE_W;
    localparam int unsigned NUM_WORDS  = PAT_BYTES / WORD_BYTES;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

    // configuration as seen by the compare logic
    typedef struct packed {
        logic [LEN_W-1:0]                  length;
        logic [PAT_BYTES-1:0][BYTE_W-1:0]  pattern;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfms_cfg.sv =====
// sfms_cfg: pattern length and pattern word registers with a plain write port
// depends on sfms_pkg
`default_nettype none

module sfms_cfg
    import sfms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    logic [LEN_W-1:0]                  pattern_length_reg;
    logic [NUM_WORDS-1:0][CFG_W-1:0]   pattern_words_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            pattern_words_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PATTERN_LENGTH: pattern_length_reg   <= cfg_wdata[LEN_W-1:0];
                REG_PATTERN_WORD_0: pattern_words_reg[0] <= cfg_wdata;
                REG_PATTERN_WORD_1: pattern_words_reg[1] <= cfg_wdata;
                REG_PATTERN_WORD_2: pattern_words_reg[2] <= cfg_wdata;
                REG_PATTERN_WORD_3: pattern_words_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // byte 0 of the pattern sits in the low bits of word 0
    assign cfg.length  = pattern_length_reg;
    assign cfg.pattern = pattern_words_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sfms_match.sv =====
// sfms_match: per-prefix partial match vector, one bit per pattern length
// depends on sfms_pkg
`default_nettype none

module sfms_match
    import sfms_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic              clear,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  cfg_t                   cfg,
    output logic                   hit
);

    // bit k set: the last k+1 text bytes equal pattern bytes 0..k
    logic [MAX_PATTERN-1:0] prefix_reg;
    logic [MAX_PATTERN-1:0] prefix_next;
    logic [MAX_PATTERN-1:0] len_sel;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k == 0) begin
                prefix_next[k] = (text_byte == cfg.pattern[k]);
            end else begin
                prefix_next[k] = (text_byte == cfg.pattern[k]) && prefix_reg[k-1];
            end
            len_sel[k] = (cfg.length == LEN_W'(k + 1));
        end
    end

    // empty or too long pattern selects no bit
    assign hit = |(prefix_next & len_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
        end else if (clear) begin
            prefix_reg <= '0;
        end else if (step_en) begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/substring_first_match_search.sv =====
// substring_first_match_search: top level, stream ports, position tracking, result register
// depends on sfms_pkg, sfms_cfg and sfms_match
//
// usage
//   s_ channel: one text byte per transaction, a zero byte ends the text
//   m_ channel: one result transaction per terminator, nothing for other bytes
//   cfg port: write pattern_length and pattern words 0..3 while the block is idle
//   every accepted text byte is compared in the same cycle against all pattern
//   prefixes at once; a partial match vector carries the history between bytes
//   the result is registered and is on m_ in the cycle after the terminator transaction
//   throughput: one byte per cycle; while m_tready is high a waiting result
//   leaves in the same cycle that the next byte is taken
//   stall: while a result waits and m_tready is low, s_tready is low
//   reset: clears the pattern registers, all per-text state and the result
//   valid; no clearing pass, the block is ready in the first cycle after reset
//   an empty pattern reports found at offset 0; a pattern longer than
//   MAX_PATTERN never matches
//   position counts saturate at MAX_TEXT-1 and set text_too_long
`default_nettype none

module substring_first_match_search
    import sfms_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int unsigned MAX_TEXT    = MAX_TEXT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // text input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,    // [7:0] text_byte
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata     // [0] found, [16:1] match_offset,
                                                  // [17] text_too_long, [23:18] zero
);

    localparam int unsigned POS_W = $clog2(MAX_TEXT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT - 1);

    cfg_t cfg;
    logic hit;

    // handshake
    logic s_accept;
    logic text_step;
    logic text_end;

    // per-text state
    logic [POS_W-1:0] byte_position_reg;
    logic             position_overflow_reg;
    logic             match_seen_reg;
    logic [POS_W-1:0] first_offset_reg;
    logic [POS_W-1:0] offset_calc;

    // result register
    logic                m_tvalid_reg;
    logic                found_reg;
    logic [OFFSET_W-1:0] match_offset_reg;
    logic                text_too_long_reg;
    logic [POS_W+OFFSET_W-1:0] offset_ext;
    logic                empty_pattern;

    sfms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfms_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (text_step),
        .clear     (text_end),
        .text_byte (s_tdata[BYTE_W-1:0]),
        .cfg       (cfg),
        .hit       (hit)
    );

    // input stalls only while a finished result is blocked
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign text_end  = s_accept && (s_tdata[BYTE_W-1:0] == '0);
    assign text_step = s_accept && (s_tdata[BYTE_W-1:0] != '0);

    // start offset of a match ending at the current byte
    assign offset_calc = byte_position_reg - POS_W'(cfg.length) + POS_W'(1);

    assign empty_pattern = (cfg.length == '0);
    // zero-extend or truncate the position-width offset to the 16-bit field
    assign offset_ext = {{OFFSET_W{1'b0}}, first_offset_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg     <= '0;
            position_overflow_reg <= 1'b0;
            match_seen_reg        <= 1'b0;
            first_offset_reg      <= '0;
        end else if (text_end) begin
            byte_position_reg     <= '0;
            position_overflow_reg <= 1'b0;
            match_seen_reg        <= 1'b0;
            first_offset_reg      <= '0;
        end else if (text_step) begin
            // saturate at the last position and flag the overflow
            if (byte_position_reg == POS_LAST) begin
                position_overflow_reg <= 1'b1;
            end else begin
                byte_position_reg <= byte_position_reg + POS_W'(1);
            end
            // keep only the first occurrence
            if (!match_seen_reg && hit) begin
                match_seen_reg   <= 1'b1;
                first_offset_reg <= offset_calc;
            end
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (text_end) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload, loaded on the terminator transaction
    always_ff @(posedge aclk) begin
        if (text_end) begin
            text_too_long_reg <= position_overflow_reg;
            if (empty_pattern) begin
                found_reg        <= 1'b1;
                match_offset_reg <= '0;
            end else if (match_seen_reg) begin
                found_reg        <= 1'b1;
                match_offset_reg <= offset_ext[OFFSET_W-1:0];
            end else begin
                found_reg        <= 1'b0;
                match_offset_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {
        (M_DATA_W - OFFSET_W - 2)'(0),
        text_too_long_reg,
        match_offset_reg,
        found_reg
    };

endmodule

`default_nettype wire

// ===== tb/sfms_match_tracker.sv =====
// sfms_match_tracker: watches the cfg, s_ and m_ ports of the substring search,
// tracks the first match per text and compares every result transaction
// depends on sfms_pkg only
`timescale 1ns / 100ps

module sfms_match_tracker
    import sfms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_DATA_W-1:0]  m_tdata,
    output int                        fail_count,
    output int                        pending
);

    localparam int unsigned WIN_DEPTH = MAX_PATTERN_DEF - 1;
    localparam int unsigned POS_LIMIT = MAX_TEXT_DEF - 1;

    // last field at the lowest bit
    typedef struct packed {
        logic                too_long;
        logic [OFFSET_W-1:0] offset;
        logic                found;
    } search_outcome_t;

    logic [LEN_W-1:0]  pat_len;
    logic [CFG_W-1:0]  pat_word [NUM_WORDS];
    logic [BYTE_W-1:0] history [WIN_DEPTH];
    int unsigned       text_pos;
    bit                pos_saturated;
    bit                hit_seen;
    logic [OFFSET_W-1:0] hit_offset;
    int unsigned       hist_fill;

    search_outcome_t predicted_outcomes [$];
    int outcomes_predicted = 0;
    int outcomes_checked   = 0;

    assign pending = outcomes_predicted - outcomes_checked;

    function automatic logic [BYTE_W-1:0] pattern_byte_at(input int unsigned k);
        logic [CFG_W-1:0] word;
        word = pat_word[(k >> 3) & 3];
        return word[(k & 7) * BYTE_W +: BYTE_W];
    endfunction

    task automatic clear_text();
        foreach (history[i]) history[i] = '0;
        text_pos      = 0;
        pos_saturated = 1'b0;
        hit_seen      = 1'b0;
        hit_offset    = '0;
        hist_fill     = 0;
    endtask

    always @(posedge aclk) begin : track
        search_outcome_t want;
        search_outcome_t got;
        logic [BYTE_W-1:0] text_b;
        int unsigned plen;
        int unsigned here;
        bit hit;
        if (!aresetn) begin
            fail_count = 0;
            pat_len = '0;
            foreach (pat_word[w]) pat_word[w] = '0;
            clear_text();
            predicted_outcomes.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PATTERN_LENGTH: pat_len = cfg_wdata[LEN_W-1:0];
                    REG_PATTERN_WORD_0: pat_word[0] = cfg_wdata;
                    REG_PATTERN_WORD_1: pat_word[1] = cfg_wdata;
                    REG_PATTERN_WORD_2: pat_word[2] = cfg_wdata;
                    REG_PATTERN_WORD_3: pat_word[3] = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                plen = 32'(pat_len);
                if (s_tdata == '0) begin
                    // terminator: one outcome, then a fresh text
                    want.found    = (plen == 0) ? 1'b1 : hit_seen;
                    want.offset   = (plen == 0 || !hit_seen) ? '0 : hit_offset;
                    want.too_long = pos_saturated;
                    predicted_outcomes.push_back(want);
                    outcomes_predicted <= outcomes_predicted + 1;
                    clear_text();
                end else begin
                    here = text_pos;
                    if (text_pos >= POS_LIMIT)
                        pos_saturated = 1'b1;
                    else
                        text_pos++;
                    // only the first occurrence counts; too long a pattern never fits
                    if (!hit_seen && plen != 0 && plen <= MAX_PATTERN_DEF
                            && hist_fill + 1 >= plen) begin
                        hit = 1'b1;
                        for (int unsigned k = 0; k < plen; k++) begin
                            if (k == plen - 1)
                                text_b = s_tdata;
                            else
                                text_b = history[plen - 2 - k];
                            if (text_b != pattern_byte_at(k))
                                hit = 1'b0;
                        end
                        if (hit) begin
                            hit_seen   = 1'b1;
                            hit_offset = OFFSET_W'(here - (plen - 1));
                        end
                    end
                    for (int i = WIN_DEPTH - 1; i > 0; i--)
                        history[i] = history[i - 1];
                    history[0] = s_tdata;
                    if (hist_fill < WIN_DEPTH)
                        hist_fill++;
                end
            end

            if (m_tvalid && m_tready) begin
                got = search_outcome_t'(m_tdata[$bits(search_outcome_t)-1:0]);
                if (m_tdata[M_DATA_W-1:$bits(search_outcome_t)] != '0) begin
                    $display("%0t: padding expected 0 actual %0h", $time,
                             m_tdata[M_DATA_W-1:$bits(search_outcome_t)]);
                    fail_count++;
                end
                if (predicted_outcomes.size() == 0) begin
                    $display("%0t: result expected none actual %0h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_outcomes.pop_front();
                    outcomes_checked <= outcomes_checked + 1;
                    if (got.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 want.found, got.found);
                        fail_count++;
                    end
                    if (got.offset !== want.offset) begin
                        $display("%0t: match_offset expected %0d actual %0d", $time,
                                 want.offset, got.offset);
                        fail_count++;
                    end
                    if (got.too_long !== want.too_long) begin
                        $display("%0t: text_too_long expected %0b actual %0b", $time,
                                 want.too_long, got.too_long);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_substring_first_match_search.sv =====
// tb_substring_first_match_search: stimulus and verdict for the substring search
// depends on sfms_pkg, substring_first_match_search and sfms_match_tracker
`timescale 1ns / 100ps

module tb_substring_first_match_search;
    import sfms_pkg::*;

    localparam int unsigned IDLE_PCT      = 11;     // idle cycles per hundred, each side
    localparam int unsigned HOLD_CYCLES   = 400;    // one long receiver hold-off
    localparam int unsigned SETTLE_CYCLES = 4;      // result lands in the cycle after its terminator
    localparam int unsigned RANDOM_ITEMS  = 1700;
    localparam int unsigned CALM_FROM     = 700;    // stretch with no idling on either side
    localparam int unsigned CALM_TO       = 1000;
    localparam int unsigned DRAIN_LIMIT   = 10000;
    localparam logic [BYTE_W-1:0] TEXT_END = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_A   = 8'h61;  // 'a', base of the small alphabet
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_PATTERN_WORD_3 + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;      // [7:0] text_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;      // [0] found, [16:1] match_offset, [17] text_too_long

    int fail_count;
    int pending;

    // stimulus side state
    bit          calm;           // no idling on either side while set
    bit          hold_req;       // asks the receiver for its one long hold-off
    int unsigned sent_items = 0;
    int unsigned cur_len;
    logic [BYTE_W-1:0] pat_bytes [PAT_BYTES];

    substring_first_match_search DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sfms_match_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // one text byte per call; returns in the step of the accepting edge
    // with s_tvalid still high, so the next call can follow back to back
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    // a text from a string, followed by its terminator
    task automatic send_string(input string txt);
        foreach (txt[i]) send_byte(txt[i]);
        send_byte(TEXT_END);
    endtask

    // leaves cfg_wr_en high; the caller lowers it once after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // write length and all pattern words from pat_bytes, only once the block is idle
    task automatic load_pattern(input logic [LEN_W-1:0] len);
        logic [CFG_W-1:0] word;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        // upper bits of the length write carry noise
        word = {$urandom, $urandom};
        word[LEN_W-1:0] = len;
        write_reg(REG_PATTERN_LENGTH, word);
        for (int w = 0; w < NUM_WORDS; w++) begin
            for (int b = 0; b < WORD_BYTES; b++)
                word[b * BYTE_W +: BYTE_W] = pat_bytes[w * WORD_BYTES + b];
            write_reg(REG_PATTERN_WORD_0 + CFG_IDX_W'(w), word);
        end
        // now and then a write to an index with no register behind it
        if ($urandom_range(4) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        cur_len = 32'(len);
    endtask

    task automatic random_pattern();
        int unsigned r;
        int unsigned style;
        int unsigned len;
        int unsigned used;
        r = $urandom_range(99);
        if (r < 5)
            len = 0;
        else if (r < 13)
            len = PAT_BYTES;
        else if (r < 18)
            len = $urandom_range(PAT_BYTES + 1, (1 << LEN_W) - 1);
        else if (r < 28)
            len = $urandom_range(9, PAT_BYTES - 1);
        else
            len = $urandom_range(1, 8);
        used  = (len > PAT_BYTES) ? PAT_BYTES : len;
        style = $urandom_range(99);
        foreach (pat_bytes[k]) begin
            if (k >= used)
                pat_bytes[k] = BYTE_W'($urandom_range(0, 255));
            else if (style < 15)
                pat_bytes[k] = BYTE_W'($urandom_range(1, 255));
            else
                pat_bytes[k] = FILL_A + BYTE_W'($urandom_range(2));
        end
        // a zero byte in the pattern can never be matched by text
        if (style >= 92 && used != 0)
            pat_bytes[$urandom_range(0, used - 1)] = '0;
        load_pattern(LEN_W'(len));
    endtask

    // mostly texts with the pattern planted in small-alphabet filler, some pure filler,
    // some noise over the whole byte range
    task automatic random_text();
        int unsigned kind;
        int unsigned n;
        int unsigned at1;
        int unsigned at2;
        int unsigned copy_len;
        logic [BYTE_W-1:0] b;
        kind     = $urandom_range(99);
        n        = ($urandom_range(9) == 0) ? $urandom_range(41, 100) : $urandom_range(0, 40);
        at1      = $urandom_range(0, n);
        at2      = ($urandom_range(2) == 0) ? $urandom_range(0, n) : n + 1;
        copy_len = (cur_len > PAT_BYTES) ? PAT_BYTES : cur_len;
        for (int unsigned i = 0; i <= n; i++) begin
            if (kind < 70 && (i == at1 || i == at2)) begin
                for (int unsigned k = 0; k < copy_len; k++)
                    send_byte(pat_bytes[k] == '0 ? FILL_A : pat_bytes[k]);
            end
            if (i < n) begin
                if (kind < 90)
                    b = FILL_A + BYTE_W'($urandom_range(2));
                else
                    b = BYTE_W'($urandom_range(1, 255));
                send_byte(b);
            end
        end
        send_byte(TEXT_END);
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int unsigned held;
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int unsigned rand_start;
        int unsigned waited;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        calm      <= 1'b0;
        hold_req  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty pattern with all-zero words: found at offset 0, even for an empty text
        foreach (pat_bytes[k]) pat_bytes[k] = '0;
        load_pattern('0);
        send_byte(TEXT_END);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(TEXT_END);

        // short pattern, the second occurrence must not move the offset
        foreach (pat_bytes[k]) pat_bytes[k] = BYTE_W'($urandom_range(0, 255));
        pat_bytes[0] = "a";
        pat_bytes[1] = "b";
        pat_bytes[2] = "c";
        load_pattern(LEN_W'(3));
        send_string("xabcabc");

        // length beyond the pattern store never matches
        foreach (pat_bytes[k]) pat_bytes[k] = "a";
        load_pattern('1);
        send_string("aaa");

        // zero byte inside the pattern
        pat_bytes[1] = '0;
        load_pattern(LEN_W'(2));
        send_string("ab");

        // single byte pattern, all-ones words
        foreach (pat_bytes[k]) pat_bytes[k] = 8'hFF;
        load_pattern(LEN_W'(1));
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(TEXT_END);

        // random phases: a new pattern, then a handful of texts
        rand_start = sent_items;
        while (sent_items - rand_start < RANDOM_ITEMS) begin
            random_pattern();
            calm     <= (sent_items - rand_start >= CALM_FROM)
                        && (sent_items - rand_start < CALM_TO);
            hold_req <= 1'b1;
            repeat ($urandom_range(3, 8)) random_text();
        end

        // drain and give the verdict
        s_tvalid <= 1'b0;
        for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
